>>> hdl/rrn_pkg.sv
`timescale 1ns / 1ps

package rrn_pkg;

  localparam int COORD_BITS = 24;

  typedef enum logic [1:0] {
    SHAPE_RECT    = 2'd0,
    SHAPE_OVAL    = 2'd1,
    SHAPE_SIMPLE  = 2'd2,
    SHAPE_COMPLEX = 2'd3
  } shape_kind_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left_edge;
    logic signed [COORD_BITS-1:0] top_edge;
    logic signed [COORD_BITS-1:0] right_edge;
    logic signed [COORD_BITS-1:0] bottom_edge;
    logic signed [COORD_BITS-1:0] top_left_rx;
    logic signed [COORD_BITS-1:0] top_left_ry;
    logic signed [COORD_BITS-1:0] top_right_rx;
    logic signed [COORD_BITS-1:0] top_right_ry;
    logic signed [COORD_BITS-1:0] bottom_right_rx;
    logic signed [COORD_BITS-1:0] bottom_right_ry;
    logic signed [COORD_BITS-1:0] bottom_left_rx;
    logic signed [COORD_BITS-1:0] bottom_left_ry;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-2:0] out_top_left_rx;
    logic [COORD_BITS-2:0] out_top_left_ry;
    logic [COORD_BITS-2:0] out_top_right_rx;
    logic [COORD_BITS-2:0] out_top_right_ry;
    logic [COORD_BITS-2:0] out_bottom_right_rx;
    logic [COORD_BITS-2:0] out_bottom_right_ry;
    logic [COORD_BITS-2:0] out_bottom_left_rx;
    logic [COORD_BITS-2:0] out_bottom_left_ry;
    shape_kind_t           shape_kind;
  } out_item_t;

endpackage

>>> hdl/rounded_rect_radii_normalize.sv
`timescale 1ns / 1ps

// Channel | Signals                        | Carries
// --------+--------------------------------+-----------------------------------
// in      | in_valid, in_ready, in_data    | rectangle edges and corner radii
// out     | out_valid, out_ready, out_data | normalized radii and shape kind
//
// One item enters per cycle unless the output stalls; the restoring divider
// retires one quotient bit per stage.
// Four stages pick the limiting side, one multiplies, one classifies.
// Reset (rst, synchronous) clears only the stage valid bits.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.

module rounded_rect_radii_normalize (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrn_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rrn_pkg::out_item_t  out_data
);

  localparam int C  = rrn_pkg::COORD_BITS;
  localparam int ND = C - 1;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Front end and side selection pipeline, level 0 is the input register.
  logic         pv   [5];
  logic [C-1:0] pw   [5];
  logic [C-1:0] ph   [5];
  logic [C-2:0] prad [5][8];
  logic [C-1:0] pbn  [5];
  logic [C-1:0] pbd  [5];

  // Divider pipeline, level 0 is loaded from the multiplier.
  logic         dv   [ND+1];
  logic [C-1:0] dw   [ND+1];
  logic [C-1:0] dh   [ND+1];
  logic [C-1:0] dbd  [ND+1];
  logic [C-1:0] drem [ND+1][8];
  logic [C-2:0] dlow [ND+1][8];
  logic [C-2:0] dq   [ND+1][8];

  // Input decode.
  logic signed [C:0] dx, dy;
  logic [C-1:0]      w_in, h_in;
  logic [C-2:0]      rad_in [8];
  logic signed [C-1:0] raw [8];

  always_comb begin
    dx = {in_data.right_edge[C-1], in_data.right_edge}
       - {in_data.left_edge[C-1], in_data.left_edge};
    dy = {in_data.bottom_edge[C-1], in_data.bottom_edge}
       - {in_data.top_edge[C-1], in_data.top_edge};
    w_in = dx[C] ? C'(-dx) : dx[C-1:0];
    h_in = dy[C] ? C'(-dy) : dy[C-1:0];
    raw[0] = in_data.top_left_rx;
    raw[1] = in_data.top_left_ry;
    raw[2] = in_data.top_right_rx;
    raw[3] = in_data.top_right_ry;
    raw[4] = in_data.bottom_right_rx;
    raw[5] = in_data.bottom_right_ry;
    raw[6] = in_data.bottom_left_rx;
    raw[7] = in_data.bottom_left_ry;
    for (int i = 0; i < 4; i++) begin
      // A corner with either component negative becomes square.
      if (raw[2*i][C-1] || raw[2*i+1][C-1]) begin
        rad_in[2*i]   = '0;
        rad_in[2*i+1] = '0;
      end else begin
        rad_in[2*i]   = raw[2*i][C-2:0];
        rad_in[2*i+1] = raw[2*i+1][C-2:0];
      end
    end
  end

  // Side selection: sides top, right, bottom, left at levels 0 to 3.
  logic [C-1:0]   side_sum [4];
  logic [C-1:0]   side_lim [4];
  logic [2*C-1:0] prod_a   [4];
  logic [2*C-1:0] prod_b   [4];
  logic           take     [4];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      unique case (p)
        0: side_sum[p] = {1'b0, prad[p][0]} + {1'b0, prad[p][2]};
        1: side_sum[p] = {1'b0, prad[p][3]} + {1'b0, prad[p][5]};
        2: side_sum[p] = {1'b0, prad[p][4]} + {1'b0, prad[p][6]};
        default: side_sum[p] = {1'b0, prad[p][7]} + {1'b0, prad[p][1]};
      endcase
      side_lim[p] = (p % 2 == 1) ? ph[p] : pw[p];
      prod_a[p]   = side_lim[p] * pbd[p];
      prod_b[p]   = pbn[p] * side_sum[p];
      take[p]     = (side_sum[p] != '0) && (prod_a[p] < prod_b[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < 5; p++) pv[p] <= 1'b0;
    end else if (en) begin
      pv[0] <= in_valid;
      for (int p = 0; p < 4; p++) pv[p+1] <= pv[p];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw[0]  <= w_in;
      ph[0]  <= h_in;
      pbn[0] <= C'(1);
      pbd[0] <= C'(1);
      for (int i = 0; i < 8; i++) prad[0][i] <= rad_in[i];
      for (int p = 0; p < 4; p++) begin
        pw[p+1]  <= pw[p];
        ph[p+1]  <= ph[p];
        pbn[p+1] <= take[p] ? side_lim[p] : pbn[p];
        pbd[p+1] <= take[p] ? side_sum[p] : pbd[p];
        for (int i = 0; i < 8; i++) prad[p+1][i] <= prad[p][i];
      end
    end
  end

  // Multiply by the ratio numerator; a ratio of at least one becomes 1/1.
  logic           scale;
  logic [C-1:0]   bn_e, bd_e;
  logic [2*C-2:0] mprod [8];

  always_comb begin
    scale = pbn[4] < pbd[4];
    bn_e  = scale ? pbn[4] : C'(1);
    bd_e  = scale ? pbd[4] : C'(1);
    for (int i = 0; i < 8; i++) mprod[i] = prad[4][i] * bn_e;
  end

  // Restoring division, one quotient bit per level, MSB first.
  logic [C:0]   trial [ND][8];
  logic [C:0]   tdiff [ND][8];
  logic         qbit  [ND][8];

  always_comb begin
    for (int j = 0; j < ND; j++) begin
      for (int i = 0; i < 8; i++) begin
        trial[j][i] = {drem[j][i], dlow[j][i][C-2]};
        tdiff[j][i] = trial[j][i] - {1'b0, dbd[j]};
        qbit[j][i]  = trial[j][i] >= {1'b0, dbd[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= ND; j++) dv[j] <= 1'b0;
    end else if (en) begin
      dv[0] <= pv[4];
      for (int j = 0; j < ND; j++) dv[j+1] <= dv[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dw[0]  <= pw[4];
      dh[0]  <= ph[4];
      dbd[0] <= bd_e;
      for (int i = 0; i < 8; i++) begin
        // The quotient stays below 2^(C-1), so the upper part starts below the divisor.
        drem[0][i] <= mprod[i][2*C-2:C-1];
        dlow[0][i] <= mprod[i][C-2:0];
        dq[0][i]   <= '0;
      end
      for (int j = 0; j < ND; j++) begin
        dw[j+1]  <= dw[j];
        dh[j+1]  <= dh[j];
        dbd[j+1] <= dbd[j];
        for (int i = 0; i < 8; i++) begin
          drem[j+1][i] <= qbit[j][i] ? tdiff[j][i][C-1:0] : trial[j][i][C-1:0];
          dlow[j+1][i] <= {dlow[j][i][C-3:0], 1'b0};
          dq[j+1][i]   <= {dq[j][i][C-3:0], qbit[j][i]};
        end
      end
    end
  end

  // Square off corners with a zero component, then classify.
  logic [C-2:0]         fr [8];
  logic                 all_zero, all_equal, is_oval;
  rrn_pkg::shape_kind_t kind;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dq[ND][2*i] == '0 || dq[ND][2*i+1] == '0) begin
        fr[2*i]   = '0;
        fr[2*i+1] = '0;
      end else begin
        fr[2*i]   = dq[ND][2*i];
        fr[2*i+1] = dq[ND][2*i+1];
      end
    end
    all_zero = 1'b1;
    for (int i = 0; i < 8; i++) if (fr[i] != '0) all_zero = 1'b0;
    all_equal = (fr[0] == fr[2]) && (fr[2] == fr[4]) && (fr[4] == fr[6])
             && (fr[1] == fr[3]) && (fr[3] == fr[5]) && (fr[5] == fr[7]);
    is_oval = ({fr[0], 1'b0} >= dw[ND]) && ({fr[1], 1'b0} >= dh[ND]);
    priority if (dw[ND] == '0 || dh[ND] == '0 || all_zero) begin
      kind = rrn_pkg::SHAPE_RECT;
    end else if (all_equal) begin
      kind = is_oval ? rrn_pkg::SHAPE_OVAL : rrn_pkg::SHAPE_SIMPLE;
    end else begin
      kind = rrn_pkg::SHAPE_COMPLEX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.out_top_left_rx     <= fr[0];
      out_data.out_top_left_ry     <= fr[1];
      out_data.out_top_right_rx    <= fr[2];
      out_data.out_top_right_ry    <= fr[3];
      out_data.out_bottom_right_rx <= fr[4];
      out_data.out_bottom_right_ry <= fr[5];
      out_data.out_bottom_left_rx  <= fr[6];
      out_data.out_bottom_left_ry  <= fr[7];
      out_data.shape_kind          <= kind;
    end
  end

endmodule
